[hw/rtl/p2d_pkg.sv]
// shared constants, types and helpers for the 2-d pooling block
`timescale 1ns / 1ps
package p2d_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int MAX_KERNEL  = 8;
   localparam int SAMPLE_BITS = 16;

   // field and register widths
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int MAP_W     = ROW_W + 1;
   localparam int KER_W     = 4;
   localparam int PAD_W     = 3;
   localparam int CSR_W     = 4;
   localparam int CSR_IDX_W = 3;

   // derived widths
   localparam int KIDX_W  = $clog2(MAX_KERNEL + 1);
   localparam int WIN_MAX = MAX_KERNEL * MAX_KERNEL;
   localparam int CNT_W   = $clog2(WIN_MAX + 1);
   localparam int SUM_W   = SAMPLE_BITS + $clog2(WIN_MAX);
   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int SPAN_W  = MAP_W + 1;
   localparam int POS_W   = ROW_W + KER_W + 1;
   localparam int STEP_W  = $clog2(SUM_W + 1);

   // operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // pooling modes
   localparam logic MODE_MAX = 1'b0;
   localparam logic MODE_AVG = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROWS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_COLS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_ROWS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_COLS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_ROWS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_COLS    = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_SETTLE,
      ST_DIVIDE,
      ST_FINISH
   } p2d_state_type;

   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] dividend;
      logic [CNT_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                          done;
      logic signed [SAMPLE_BITS-1:0] quotient;
   } div_rsp_type;

   function automatic logic [KIDX_W-1:0] clamp_kernel(input logic [KER_W-1:0] k);
      logic [KIDX_W-1:0] res;
      if (k == '0) begin
         res = KIDX_W'(1);
      end else if (int'(k) > MAX_KERNEL) begin
         res = KIDX_W'(MAX_KERNEL);
      end else begin
         res = KIDX_W'(k);
      end
      return res;
   endfunction

   function automatic logic [KER_W-1:0] fix_stride(input logic [KER_W-1:0] s);
      return (s == '0) ? KER_W'(1) : s;
   endfunction

endpackage

[hw/rtl/p2d_req_if.sv]
// request channel: sample loads and pooled-output queries
`timescale 1ns / 1ps
interface p2d_req_if;
   import p2d_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [ROW_W-1:0]              row;
   logic [COL_W-1:0]              col;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last;

   modport source (output valid, output op, output row, output col, output sample,
                   output last, input ready);
   modport sink   (input valid, input op, input row, input col, input sample,
                   input last, output ready);
endinterface

[hw/rtl/p2d_rsp_if.sv]
// response channel: one pooled result per query
`timescale 1ns / 1ps
interface p2d_rsp_if;
   import p2d_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] pooled;
   logic                          empty_window;
   logic                          outside_grid;

   modport source (output valid, output pooled, output empty_window, output outside_grid,
                   input ready);
   modport sink   (input valid, input pooled, input empty_window, input outside_grid,
                   output ready);
endinterface

[hw/rtl/pool2d_max_avg_forward.sv]
// 2-d max / average pooling over one stored feature map
// Loads write a signed Q8.8 sample into a 64x64 sample ram and can follow
// each other back to back; the load marked last sets the map size.
// A query is accepted only when the block is idle. It checks the position
// against the output grid, then walks the kernel window one position per
// cycle through the single ram port; in average mode the window sum is then
// divided by the sample count in a bit-serial divide. The result then
// sits in an output register until it is taken, while loads keep flowing.
// The sample ram has no reset: a window must only cover written samples.
`timescale 1ns / 1ps
module pool2d_max_avg_forward (
   input  logic                          clock,
   input  logic                          reset,
   p2d_req_if.sink                       req_if,
   p2d_rsp_if.source                     rsp_if,
   input  logic                          csr_we,
   input  logic [p2d_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [p2d_pkg::CSR_W-1:0]     csr_wdata
);
   import p2d_pkg::*;

   // configuration registers
   logic             mode_cfg_ff;
   logic [KER_W-1:0] krows_cfg_ff, kcols_cfg_ff;
   logic [KER_W-1:0] srows_cfg_ff, scols_cfg_ff;
   logic [PAD_W-1:0] prows_cfg_ff, pcols_cfg_ff;

   logic [MAP_W-1:0] map_h_ff, map_h_in;
   logic [MAP_W-1:0] map_w_ff, map_w_in;

   p2d_state_type    state_ff, state_in;

   logic                          mode_ff, mode_in;
   logic [KIDX_W-1:0]             kr_ff, kr_in, kc_ff, kc_in;
   logic [KIDX_W-1:0]             i_ff, i_in, j_ff, j_in;
   logic signed [POS_W-1:0]       r0_ff, r0_in, c0_ff, c0_in;
   logic signed [SAMPLE_BITS-1:0] best_ff, best_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          rd_valid_ff, rd_valid_in;

   logic signed [SAMPLE_BITS-1:0] res_pooled_ff, res_pooled_in;
   logic                          res_empty_ff, res_empty_in;
   logic                          res_outside_ff, res_outside_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_pooled_ff, rsp_pooled_in;
   logic                          rsp_empty_ff, rsp_empty_in;
   logic                          rsp_outside_ff, rsp_outside_in;

   // accept-time grid check
   logic                    req_xfer;
   logic [KIDX_W-1:0]       kr_eff, kc_eff;
   logic [KER_W-1:0]        sr_eff, sc_eff;
   logic [SPAN_W-1:0]       span_r, span_c;
   logic [POS_W-1:0]        rs, cs;
   logic                    past_r, past_c;
   logic                    load_ok;

   // window walk
   logic signed [POS_W-1:0]       r_pos, c_pos;
   logic                          in_map;
   logic                          last_col, last_pos;
   logic [ADDR_W-1:0]             load_addr, walk_addr, ram_addr;
   logic                          ram_we;
   logic signed [SAMPLE_BITS-1:0] ram_rdata;
   logic signed [SAMPLE_BITS-1:0] best_acc;
   logic signed [SUM_W-1:0]       sum_acc;
   logic [CNT_W-1:0]              count_acc;

   div_req_type div_req;
   div_rsp_type div_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_cfg_ff  <= MODE_MAX;
         krows_cfg_ff <= KER_W'(2);
         kcols_cfg_ff <= KER_W'(2);
         srows_cfg_ff <= KER_W'(2);
         scols_cfg_ff <= KER_W'(2);
         prows_cfg_ff <= '0;
         pcols_cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_POOL_MODE:   mode_cfg_ff  <= csr_wdata[0];
            CSR_KERNEL_ROWS: krows_cfg_ff <= csr_wdata;
            CSR_KERNEL_COLS: kcols_cfg_ff <= csr_wdata;
            CSR_STRIDE_ROWS: srows_cfg_ff <= csr_wdata;
            CSR_STRIDE_COLS: scols_cfg_ff <= csr_wdata;
            CSR_PAD_ROWS:    prows_cfg_ff <= csr_wdata[PAD_W-1:0];
            CSR_PAD_COLS:    pcols_cfg_ff <= csr_wdata[PAD_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;

   always_comb begin
      kr_eff = clamp_kernel(krows_cfg_ff);
      kc_eff = clamp_kernel(kcols_cfg_ff);
      sr_eff = fix_stride(srows_cfg_ff);
      sc_eff = fix_stride(scols_cfg_ff);
      span_r = SPAN_W'(map_h_ff) + SPAN_W'({prows_cfg_ff, 1'b0});
      span_c = SPAN_W'(map_w_ff) + SPAN_W'({pcols_cfg_ff, 1'b0});
      rs     = POS_W'(req_if.row) * POS_W'(sr_eff);
      cs     = POS_W'(req_if.col) * POS_W'(sc_eff);
      // inside the grid iff row*stride + kernel <= map + 2*pad
      past_r = (rs + POS_W'(kr_eff)) > POS_W'(span_r);
      past_c = (cs + POS_W'(kc_eff)) > POS_W'(span_c);
      load_ok = (int'(req_if.row) < MAX_ROWS) && (int'(req_if.col) < MAX_COLS);
      load_addr = ADDR_W'(int'(req_if.row) * MAX_COLS + int'(req_if.col));
   end

   always_comb begin
      r_pos    = r0_ff + $signed(POS_W'(i_ff));
      c_pos    = c0_ff + $signed(POS_W'(j_ff));
      in_map   = !r_pos[POS_W-1] && (r_pos < $signed(POS_W'(map_h_ff)))
              && !c_pos[POS_W-1] && (c_pos < $signed(POS_W'(map_w_ff)));
      last_col = (j_ff == kc_ff - KIDX_W'(1));
      last_pos = last_col && (i_ff == kr_ff - KIDX_W'(1));
      walk_addr = ADDR_W'(int'(r_pos[ROW_W-1:0]) * MAX_COLS + int'(c_pos[COL_W-1:0]));
      best_acc  = (ram_rdata > best_ff) ? ram_rdata : best_ff;
      sum_acc   = sum_ff + SUM_W'(ram_rdata);
      count_acc = count_ff + CNT_W'(1);
   end

   assign ram_we   = req_xfer && (req_if.op == OP_LOAD) && load_ok;
   assign ram_addr = (state_ff == ST_IDLE) ? load_addr : walk_addr;

   p2d_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_if.sample),
      .rdata (ram_rdata)
   );

   p2d_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in       = state_ff;
      map_h_in       = map_h_ff;
      map_w_in       = map_w_ff;
      mode_in        = mode_ff;
      kr_in          = kr_ff;
      kc_in          = kc_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      r0_in          = r0_ff;
      c0_in          = c0_ff;
      best_in        = best_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      rd_valid_in    = 1'b0;
      res_pooled_in  = res_pooled_ff;
      res_empty_in   = res_empty_ff;
      res_outside_in = res_outside_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_pooled_in  = rsp_pooled_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_outside_in = rsp_outside_ff;
      div_req.start    = 1'b0;
      div_req.dividend = sum_ff;
      div_req.divisor  = count_ff;

      // samples read in the previous cycle
      if (rd_valid_ff) begin
         best_in  = best_acc;
         sum_in   = sum_acc;
         count_in = count_acc;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_if.op == OP_LOAD) begin
                  if (load_ok && req_if.last) begin
                     map_h_in = MAP_W'(req_if.row) + MAP_W'(1);
                     map_w_in = MAP_W'(req_if.col) + MAP_W'(1);
                  end
               end else if (past_r || past_c) begin
                  res_pooled_in  = '0;
                  res_empty_in   = 1'b0;
                  res_outside_in = 1'b1;
                  state_in       = ST_FINISH;
               end else begin
                  mode_in  = mode_cfg_ff;
                  kr_in    = kr_eff;
                  kc_in    = kc_eff;
                  r0_in    = $signed(rs) - $signed(POS_W'(prows_cfg_ff));
                  c0_in    = $signed(cs) - $signed(POS_W'(pcols_cfg_ff));
                  i_in     = '0;
                  j_in     = '0;
                  best_in  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                  sum_in   = '0;
                  count_in = '0;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            rd_valid_in = in_map;
            if (last_pos) begin
               state_in = ST_DRAIN;
            end else if (last_col) begin
               j_in = '0;
               i_in = i_ff + KIDX_W'(1);
            end else begin
               j_in = j_ff + KIDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            if (mode_ff == MODE_AVG && count_ff != '0) begin
               div_req.start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               res_pooled_in  = (mode_ff == MODE_MAX) ? best_ff : '0;
               res_empty_in   = (count_ff == '0);
               res_outside_in = 1'b0;
               state_in       = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               res_pooled_in  = div_rsp.quotient;
               res_empty_in   = 1'b0;
               res_outside_in = 1'b0;
               state_in       = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait here while an earlier result is still unclaimed
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_pooled_in  = res_pooled_ff;
               rsp_empty_in   = res_empty_ff;
               rsp_outside_in = res_outside_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_h_ff     <= '0;
         map_w_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_h_ff     <= map_h_in;
         map_w_ff     <= map_w_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      kr_ff          <= kr_in;
      kc_ff          <= kc_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      r0_ff          <= r0_in;
      c0_ff          <= c0_in;
      best_ff        <= best_in;
      sum_ff         <= sum_in;
      count_ff       <= count_in;
      res_pooled_ff  <= res_pooled_in;
      res_empty_ff   <= res_empty_in;
      res_outside_ff <= res_outside_in;
      rsp_pooled_ff  <= rsp_pooled_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_outside_ff <= rsp_outside_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.pooled       = rsp_pooled_ff;
   assign rsp_if.empty_window = rsp_empty_ff;
   assign rsp_if.outside_grid = rsp_outside_ff;

   // ram data only arrives while the window is being walked
   a_rd_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_WALK || state_ff == ST_DRAIN))
      else $error("sample read outside window walk");

   // the divider is only started for a non-empty average
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (mode_ff == MODE_AVG && count_ff != '0))
      else $error("divider started without samples");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished while not waited on");

   // never more samples than window positions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETTLE) |->
         ((2*KIDX_W)'(count_ff) <= (2*KIDX_W)'(kr_ff) * (2*KIDX_W)'(kc_ff)))
      else $error("sample count exceeds window size");

endmodule

[hw/rtl/p2d_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps
module p2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

[hw/rtl/p2d_div.sv]
// iterative signed-by-unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
module p2d_div (
   input  logic                 clock,
   input  logic                 reset,
   input  p2d_pkg::div_req_type div_req,
   output p2d_pkg::div_rsp_type div_rsp
);
   import p2d_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic              neg_ff, neg_in;

   logic [SUM_W-1:0]  mag;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    rem_sub;
   logic              ge;
   logic [SUM_W-1:0]  quo_signed;

   always_comb begin
      mag     = div_req.dividend[SUM_W-1] ? SUM_W'(-div_req.dividend)
                                          : SUM_W'(div_req.dividend);
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      ge      = (rem_sh >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         rem_in  = '0;
         quo_in  = mag;
         dvs_in  = div_req.divisor;
         neg_in  = div_req.dividend[SUM_W-1];
      end else if (busy_ff) begin
         // restoring step: shift in the next dividend bit, subtract if it fits
         rem_in  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], ge};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   assign quo_signed       = neg_ff ? SUM_W'(-quo_ff) : quo_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_signed[SAMPLE_BITS-1:0];
endmodule

[bench/pool2d_max_avg_forward_tb.sv]
// self-checking testbench for the 2-d pooling block: directed and random loads and queries
`timescale 1ns / 1ps
module pool2d_max_avg_forward_tb;
   import p2d_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 100;
   localparam int IDLE_PCT = 24;
   localparam int ITEM_GOAL = 1400;

   typedef struct packed {
      logic                          op;
      logic [ROW_W-1:0]              row;
      logic [COL_W-1:0]              col;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } pool_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] pooled;
      logic                          empty_window;
      logic                          outside_grid;
   } pool_out_type;

   typedef struct packed {
      logic             mode;
      logic [KER_W-1:0] kr;
      logic [KER_W-1:0] kc;
      logic [KER_W-1:0] sr;
      logic [KER_W-1:0] sc;
      logic [PAD_W-1:0] pr;
      logic [PAD_W-1:0] pc;
   } pool_cfg_type;

   localparam pool_cfg_type CFG_AT_RESET = '{mode: MODE_MAX, kr: 4'd2, kc: 4'd2, sr: 4'd2,
                                             sc: 4'd2, pr: 3'd0, pc: 3'd0};

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [CSR_W-1:0]     csr_wdata;

   p2d_req_if req_ch ();
   p2d_rsp_if rsp_ch ();

   pool2d_max_avg_forward dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // stimulus side
   pool_req_type queued_reqs[$];
   pool_cfg_type plan_cfg;
   bit           plan_written [DEPTH];
   int           plan_h, plan_w;
   int           items_queued;
   int           hold_asks;

   // prediction side
   pool_out_type                  expected_pools[$];
   pool_cfg_type                  live_cfg;
   logic signed [SAMPLE_BITS-1:0] sample_copy [DEPTH];
   int                            map_h, map_w;
   int                            fails;

   int cycle_no;
   int idle_run;
   int hold_left;
   int holds_served;
   logic calm;

   // no random idling on either side in this part of every 16k cycles
   assign calm = (cycle_no % 16384) >= 11000;

   function automatic int eff_kernel(logic [KER_W-1:0] k);
      if (k == '0) return 1;
      if (int'(k) > MAX_KERNEL) return MAX_KERNEL;
      return int'(k);
   endfunction

   function automatic int eff_stride(logic [KER_W-1:0] s);
      return (s == '0) ? 1 : int'(s);
   endfunction

   function automatic int grid_extent(int extent, int pad, int k, int s);
      if (extent + 2 * pad < k) return 0;
      return (extent + 2 * pad - k) / s + 1;
   endfunction

   function automatic pool_cfg_type with_reg(pool_cfg_type c, logic [CSR_IDX_W-1:0] idx,
                                             logic [CSR_W-1:0] d);
      case (idx)
         CSR_POOL_MODE:   c.mode = d[0];
         CSR_KERNEL_ROWS: c.kr = d;
         CSR_KERNEL_COLS: c.kc = d;
         CSR_STRIDE_ROWS: c.sr = d;
         CSR_STRIDE_COLS: c.sc = d;
         CSR_PAD_ROWS:    c.pr = d[PAD_W-1:0];
         CSR_PAD_COLS:    c.pc = d[PAD_W-1:0];
         default: ;
      endcase
      return c;
   endfunction

   // max or truncated average over the window at an output position
   function automatic pool_out_type pool_window(int qr, int qc);
      pool_out_type res;
      int kr, kc, sr, sc, pr, pc, r0, c0, best, total, hits, v;
      kr = eff_kernel(live_cfg.kr);
      kc = eff_kernel(live_cfg.kc);
      sr = eff_stride(live_cfg.sr);
      sc = eff_stride(live_cfg.sc);
      pr = int'(live_cfg.pr);
      pc = int'(live_cfg.pc);
      res = '0;
      if (qr >= grid_extent(map_h, pr, kr, sr) || qc >= grid_extent(map_w, pc, kc, sc)) begin
         res.outside_grid = 1'b1;
         return res;
      end
      r0 = qr * sr - pr;
      c0 = qc * sc - pc;
      best = -(1 << (SAMPLE_BITS - 1));
      total = 0;
      hits = 0;
      for (int i = 0; i < kr; i++) begin
         for (int j = 0; j < kc; j++) begin
            if (r0 + i >= 0 && r0 + i < map_h && c0 + j >= 0 && c0 + j < map_w) begin
               v = int'(sample_copy[(r0 + i) * MAX_COLS + c0 + j]);
               if (v > best) best = v;
               total += v;
               hits++;
            end
         end
      end
      res.empty_window = (hits == 0);
      if (live_cfg.mode == MODE_MAX) begin
         res.pooled = SAMPLE_BITS'(best);
      end else if (hits == 0) begin
         res.pooled = '0;
      end else begin
         res.pooled = SAMPLE_BITS'(total / hits);
      end
      return res;
   endfunction

   // every entry of an h x w map already written by planned loads
   function automatic bit covered(int h, int w);
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++)
            if (!plan_written[r * MAX_COLS + c]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(15))
         0: return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
         1: return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [KER_W-1:0] rand_size();
      if ($urandom_range(7) == 0) return $urandom_range(1) ? KER_W'(15) : KER_W'(0);
      return KER_W'($urandom_range(1, MAX_KERNEL));
   endfunction

   // a last mark is only kept when the map it defines is fully written
   task automatic push_load(int r, int c, logic signed [SAMPLE_BITS-1:0] s, bit want_last);
      pool_req_type it;
      plan_written[r * MAX_COLS + c] = 1'b1;
      it.op = OP_LOAD;
      it.row = ROW_W'(r);
      it.col = COL_W'(c);
      it.sample = s;
      it.last = want_last && covered(r + 1, c + 1);
      if (it.last) begin
         plan_h = r + 1;
         plan_w = c + 1;
      end
      queued_reqs.push_back(it);
      items_queued++;
   endtask

   task automatic push_query(int r, int c);
      pool_req_type it;
      it.op = OP_QUERY;
      it.row = ROW_W'(r);
      it.col = COL_W'(c);
      it.sample = rand_sample();
      it.last = 1'($urandom_range(1));
      queued_reqs.push_back(it);
      items_queued++;
   endtask

   task automatic push_some_query();
      int oh, ow;
      oh = grid_extent(plan_h, int'(plan_cfg.pr), eff_kernel(plan_cfg.kr),
                       eff_stride(plan_cfg.sr));
      ow = grid_extent(plan_w, int'(plan_cfg.pc), eff_kernel(plan_cfg.kc),
                       eff_stride(plan_cfg.sc));
      if (oh > MAX_ROWS) oh = MAX_ROWS;
      if (ow > MAX_COLS) ow = MAX_COLS;
      if (oh > 0 && ow > 0 && $urandom_range(9) != 0) begin
         push_query(int'($urandom_range(oh - 1)), int'($urandom_range(ow - 1)));
      end else begin
         push_query(int'($urandom_range(MAX_ROWS - 1)), int'($urandom_range(MAX_COLS - 1)));
      end
   endtask

   task automatic load_map(int h, int w);
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++)
            push_load(r, c, rand_sample(), r == h - 1 && c == w - 1);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] d);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= d;
   endtask

   task automatic set_config(pool_cfg_type c);
      write_reg(CSR_POOL_MODE, CSR_W'(c.mode));
      write_reg(CSR_KERNEL_ROWS, c.kr);
      write_reg(CSR_KERNEL_COLS, c.kc);
      write_reg(CSR_STRIDE_ROWS, c.sr);
      write_reg(CSR_STRIDE_COLS, c.sc);
      write_reg(CSR_PAD_ROWS, CSR_W'(c.pr));
      write_reg(CSR_PAD_COLS, CSR_W'(c.pc));
      @(posedge clock);
      csr_we <= 1'b0;
      plan_cfg = c;
   endtask

   // sender pauses until everything is sent and every result is back
   task automatic settle();
      while (queued_reqs.size() != 0 || req_ch.valid || expected_pools.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      pool_req_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (queued_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            nxt = queued_reqs.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.op <= nxt.op;
            req_ch.row <= nxt.row;
            req_ch.col <= nxt.col;
            req_ch.sample <= nxt.sample;
            req_ch.last <= nxt.last;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result ready, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= 0;
         holds_served <= 0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_asks) begin
         holds_served <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // prediction and checking
   always @(posedge clock) begin
      pool_out_type want;
      if (reset) begin
         live_cfg = CFG_AT_RESET;
         map_h = 0;
         map_w = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pools.size() == 0) begin
               $error("result transfer with no query outstanding");
               fails++;
            end else begin
               want = expected_pools.pop_front();
               if (rsp_ch.pooled !== want.pooled) begin
                  $error("pooled: expected %0d, got %0d", want.pooled, rsp_ch.pooled);
                  fails++;
               end
               if (rsp_ch.empty_window !== want.empty_window) begin
                  $error("empty_window: expected %0b, got %0b", want.empty_window,
                         rsp_ch.empty_window);
                  fails++;
               end
               if (rsp_ch.outside_grid !== want.outside_grid) begin
                  $error("outside_grid: expected %0b, got %0b", want.outside_grid,
                         rsp_ch.outside_grid);
                  fails++;
               end
            end
         end
         if (csr_we) live_cfg = with_reg(live_cfg, csr_idx, csr_wdata);
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.op == OP_LOAD) begin
               sample_copy[int'(req_ch.row) * MAX_COLS + int'(req_ch.col)] = req_ch.sample;
               if (req_ch.last) begin
                  map_h = int'(req_ch.row) + 1;
                  map_w = int'(req_ch.col) + 1;
               end
            end else begin
               expected_pools.push_back(pool_window(int'(req_ch.row), int'(req_ch.col)));
            end
         end
      end
   end

   // watchdog on cycles without any transfer or register write
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (reset || csr_we || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_run <= 0;
      end else if (idle_run == STALL_LIMIT) begin
         $display("pool2d_max_avg_forward test failed");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   initial begin
      int corner_vals [9] = '{32767, -32768, -1, 0, 1, -256, 256, 32512, -300};
      int pick, h, w, phase;
      pool_cfg_type cfg;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.op = OP_LOAD;
      req_ch.row = '0;
      req_ch.col = '0;
      req_ch.sample = '0;
      req_ch.last = 1'b0;
      rsp_ch.ready = 1'b0;
      cycle_no = 0;
      idle_run = 0;
      hold_asks = 0;
      fails = 0;
      items_queued = 0;
      plan_cfg = CFG_AT_RESET;
      plan_h = 0;
      plan_w = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: query before any map, then a 3x3 map of extreme samples
      push_query(0, 0);
      for (int i = 0; i < 9; i++) push_load(i / 3, i % 3, SAMPLE_BITS'(corner_vals[i]), i == 8);
      push_query(0, 0);
      push_query(1, 0);
      push_query(0, 1);
      settle();

      // zero and oversized kernel, zero stride, full padding, average mode
      cfg = '{mode: MODE_AVG, kr: 4'd15, kc: 4'd0, sr: 4'd0, sc: 4'd8, pr: 3'd7, pc: 3'd7};
      set_config(cfg);
      push_query(0, 0);
      push_query(5, 1);
      push_query(9, 2);
      push_query(63, 63);
      settle();

      // same window in max mode; far corner load, then shrink the map to 1x1
      cfg.mode = MODE_MAX;
      set_config(cfg);
      push_query(0, 0);
      push_query(5, 1);
      push_load(63, 63, rand_sample(), 1'b0);
      push_load(0, 0, rand_sample(), 1'b1);
      push_query(0, 0);
      settle();

      // map smaller than the kernel: empty grid
      cfg = '{mode: MODE_MAX, kr: 4'd8, kc: 4'd8, sr: 4'd1, sc: 4'd1, pr: 3'd0, pc: 3'd0};
      set_config(cfg);
      push_query(0, 0);
      settle();

      phase = 0;
      while (items_queued < ITEM_GOAL) begin
         cfg.mode = $urandom_range(1) ? MODE_AVG : MODE_MAX;
         cfg.kr = rand_size();
         cfg.kc = rand_size();
         cfg.sr = rand_size();
         cfg.sc = rand_size();
         cfg.pr = ($urandom_range(3) == 0) ? PAD_W'($urandom_range(7))
                                          : PAD_W'($urandom_range(2));
         cfg.pc = ($urandom_range(3) == 0) ? PAD_W'($urandom_range(7))
                                          : PAD_W'($urandom_range(2));
         set_config(cfg);
         if (phase == 2) hold_asks <= hold_asks + 1;
         if (phase == 1) begin
            load_map(MAX_ROWS, 2);
         end else if (phase == 4) begin
            load_map(2, MAX_COLS);
         end else if (plan_h == 0 || $urandom_range(1) == 0) begin
            h = $urandom_range(1, 10);
            w = $urandom_range(1, 10);
            load_map(h, w);
         end
         repeat ($urandom_range(40, 100)) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               push_some_query();
            end else if (pick < 85 && plan_h != 0) begin
               push_load($urandom_range(plan_h - 1), $urandom_range(plan_w - 1), rand_sample(),
                         $urandom_range(9) == 0);
            end else begin
               push_load($urandom_range(MAX_ROWS - 1), $urandom_range(MAX_COLS - 1),
                         rand_sample(), $urandom_range(3) == 0);
            end
         end
         settle();
         phase++;
      end

      if (fails == 0) begin
         $display("pool2d_max_avg_forward test passed");
      end else begin
         $display("pool2d_max_avg_forward test failed");
      end
      $finish;
   end

endmodule
